### rtl/core/websocket_frame_deframer_unmasker_assert.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASKER_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer and unmasker.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LIMIT   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECT_MASKED = 4'd1;

   localparam int unsigned FRAME_LIMIT_WIDTH = 31;
   localparam logic [FRAME_LIMIT_WIDTH-1:0] FRAME_LIMIT_RESET = 31'd65535;

   // header decoding constants
   localparam logic [6:0]  LEN_CODE_EXT16   = 7'd126;
   localparam logic [6:0]  LEN_CODE_EXT64   = 7'd127;
   localparam logic [3:0]  EXT16_BYTES      = 4'd2;
   localparam logic [3:0]  EXT64_BYTES      = 4'd8;
   localparam logic [3:0]  BASE_HDR_BYTES   = 4'd2;
   localparam logic [3:0]  MASK_KEY_BYTES   = 4'd4;
   localparam logic [63:0] SHORT_LEN_MAX    = 64'd125;
   localparam logic [63:0] EXT16_LEN_MAX    = 64'hffff;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_FIRST = 5'b00001,
      PH_LEN   = 5'b00010,
      PH_EXT   = 5'b00100,
      PH_KEY   = 5'b01000,
      PH_DATA  = 5'b10000
   } phase_type;

   // one result word
   typedef struct packed {
      logic        is_header;
      logic [7:0]  data_byte;
      logic        fin;
      logic [2:0]  rsv_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic        last;
      logic        length_violation;
      logic        oversize;
      logic        mask_mismatch;
   } rsp_type;

endpackage

### rtl/core/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// wsd_in_reg
// Input register: captures one stream byte and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module wsd_in_reg
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // free when empty or being consumed this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

### rtl/core/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state machine: walks the header, collects length and mask key,
// unmasks payload bytes and builds the result word for the output register.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_unmasker_assert.svh"

module wsd_parser
   import wsd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [7:0]                   in_byte,
   input  logic [FRAME_LIMIT_WIDTH-1:0] frame_limit,
   input  logic                         expect_masked,
   output logic                         res_valid,
   output rsp_type                      res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  first_hdr_ff, first_hdr_in;
   logic        mask_flag_ff, mask_flag_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [3:0]  ext_size_ff, ext_size_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic        drop_ff, drop_in;

   logic                         hdr_done;
   logic                         data_emit;
   logic                         data_last;
   logic [7:0]                   key_byte;
   logic [3:0]                   hdr_bytes;
   logic [FRAME_LIMIT_WIDTH-1:0] room;
   logic                         over;
   logic                         empty;
   logic                         violation;

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      first_hdr_in    = first_hdr_ff;
      mask_flag_in    = mask_flag_ff;
      ext_left_in     = ext_left_ff;
      ext_size_in     = ext_size_ff;
      length_in       = length_ff;
      mask_key_in     = mask_key_ff;
      payload_left_in = payload_left_ff;
      key_index_in    = key_index_ff;
      drop_in         = drop_ff;
      hdr_done        = 1'b0;
      data_emit       = 1'b0;
      data_last       = 1'b0;

      // key byte 0 is the first key byte received (top of the word)
      unique case (key_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase

      if (step) begin
         unique case (phase_ff)
            PH_FIRST: begin
               first_hdr_in    = in_byte;
               mask_flag_in    = 1'b0;
               length_in       = '0;
               ext_size_in     = '0;
               ext_left_in     = '0;
               mask_key_in     = '0;
               key_index_in    = '0;
               payload_left_in = '0;
               drop_in         = 1'b0;
               phase_in        = PH_LEN;
            end
            PH_LEN: begin
               mask_flag_in = in_byte[7];
               if (in_byte[6:0] == LEN_CODE_EXT16 || in_byte[6:0] == LEN_CODE_EXT64) begin
                  ext_size_in = (in_byte[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  ext_left_in = ext_size_in;
                  length_in   = '0;
                  phase_in    = PH_EXT;
               end else begin
                  length_in = {57'd0, in_byte[6:0]};
                  if (in_byte[7]) begin
                     phase_in     = PH_KEY;
                     key_index_in = '0;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               // big-endian length, one byte a step
               length_in   = {length_ff[55:0], in_byte};
               ext_left_in = ext_left_ff - 4'd1;
               if (ext_left_in == 4'd0) begin
                  if (mask_flag_ff) begin
                     phase_in     = PH_KEY;
                     key_index_in = '0;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               mask_key_in = {mask_key_ff[23:0], in_byte};
               if (key_index_ff != 2'd3) begin
                  key_index_in = key_index_ff + 2'd1;
               end else begin
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               key_index_in    = key_index_ff + 2'd1;
               payload_left_in = payload_left_ff - 64'd1;
               data_last       = (payload_left_in == 64'd0);
               if (data_last) begin
                  phase_in = PH_FIRST;
               end
               data_emit = !drop_ff;
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end

      // size check against the limit: header bytes plus payload length
      hdr_bytes = BASE_HDR_BYTES + ext_size_in + (mask_flag_in ? MASK_KEY_BYTES : 4'd0);
      room      = frame_limit - {27'd0, hdr_bytes};
      over      = (frame_limit < {27'd0, hdr_bytes}) || (|length_in[63:31])
                  || (length_in[30:0] > room);
      empty     = (length_in == 64'd0);
      violation = (ext_size_in == EXT16_BYTES && length_in <= SHORT_LEN_MAX)
                  || (ext_size_in == EXT64_BYTES && length_in <= EXT16_LEN_MAX);

      if (hdr_done) begin
         key_index_in = '0;
         if (empty) begin
            phase_in = PH_FIRST;
         end else begin
            payload_left_in = length_in;
            drop_in         = over;
            phase_in        = PH_DATA;
         end
      end

      // result word
      res_valid            = hdr_done || data_emit;
      res.is_header        = hdr_done;
      res.data_byte        = hdr_done ? 8'd0 : (in_byte ^ key_byte);
      res.fin              = first_hdr_in[7];
      res.rsv_bits         = first_hdr_in[6:4];
      res.opcode           = first_hdr_in[3:0];
      res.masked           = mask_flag_in;
      res.payload_length   = length_in;
      res.last             = hdr_done ? empty : data_last;
      res.length_violation = violation;
      res.oversize         = hdr_done && over;
      res.mask_mismatch    = mask_flag_in ^ expect_masked;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         first_hdr_ff    <= '0;
         mask_flag_ff    <= 1'b0;
         ext_left_ff     <= '0;
         ext_size_ff     <= '0;
         length_ff       <= '0;
         mask_key_ff     <= '0;
         payload_left_ff <= '0;
         key_index_ff    <= '0;
         drop_ff         <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         first_hdr_ff    <= first_hdr_in;
         mask_flag_ff    <= mask_flag_in;
         ext_left_ff     <= ext_left_in;
         ext_size_ff     <= ext_size_in;
         length_ff       <= length_in;
         mask_key_ff     <= mask_key_in;
         payload_left_ff <= payload_left_in;
         key_index_ff    <= key_index_in;
         drop_ff         <= drop_in;
      end
   end

   // last payload byte returns to the first header byte
   `WSD_ASSERT_NEXT(a_last_byte_ends_frame, clock, reset, step && phase_ff == PH_DATA && payload_left_ff == 64'd1, phase_ff == PH_FIRST, "frame did not end on last payload byte")
   // an oversize frame with payload goes on to drop it
   `WSD_ASSERT_NEXT(a_oversize_drops, clock, reset, res_valid && res.is_header && res.oversize && !res.last, drop_ff && phase_ff == PH_DATA, "oversize frame payload not dropped")
   // no result at all while dropping payload
   `WSD_ASSERT_NOW(a_no_result_when_dropping, clock, reset, drop_ff && phase_ff == PH_DATA, !res_valid, "result given for dropped payload")

endmodule

### rtl/core/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result word until the consumer takes it and
// tells the parser whether a new word can be written.
// ----------------------------------------------------------------------------
module wsd_out_reg
   import wsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_word,
   output logic    room_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;

   // slot is free when empty or being taken this cycle
   assign room_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (room_free) begin
         valid_in = load;
         word_in  = load_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

### rtl/core/websocket_frame_deframer_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmasker
// Parses WebSocket frames one byte per word, gives a header event and one
// unmasked word per payload byte that is not dropped.
// ----------------------------------------------------------------------------
// An accepted byte passes the input register, then the result register, before
// its result reaches the ports; a full result slot holds the byte back.
// Throughput: one byte per cycle while the result slot is free or being taken.
// Header bytes before the last give no result; dropped payload gives none.
// Reset: synchronous, active high; parser waits for a first header byte,
// frame_limit returns to 65535 and expect_masked to 0.
module websocket_frame_deframer_unmasker
   import wsd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // input stream
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_stream_byte,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_is_header,
   output logic [7:0]                   rsp_data_byte,
   output logic                         rsp_fin,
   output logic [2:0]                   rsp_rsv_bits,
   output logic [3:0]                   rsp_opcode,
   output logic                         rsp_masked,
   output logic [63:0]                  rsp_payload_length,
   output logic                         rsp_last,
   output logic                         rsp_length_violation,
   output logic                         rsp_oversize,
   output logic                         rsp_mask_mismatch,
   // configuration writes
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [FRAME_LIMIT_WIDTH-1:0] csr_write_data
);

   logic [FRAME_LIMIT_WIDTH-1:0] frame_limit_ff, frame_limit_in;
   logic                         expect_masked_ff, expect_masked_in;

   logic       in_valid;
   logic [7:0] in_byte;
   logic       room_free;
   logic       step;
   logic       res_valid;
   rsp_type    res;
   rsp_type    rsp_word;

   // configuration registers
   always_comb begin
      frame_limit_in   = frame_limit_ff;
      expect_masked_in = expect_masked_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_LIMIT:   frame_limit_in   = csr_write_data;
            CSR_EXPECT_MASKED: expect_masked_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff   <= FRAME_LIMIT_RESET;
         expect_masked_ff <= 1'b0;
      end else begin
         frame_limit_ff   <= frame_limit_in;
         expect_masked_ff <= expect_masked_in;
      end
   end

   // parser advances whenever a byte waits and the result slot is free
   assign step = in_valid && room_free;

   wsd_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .take            (step),
      .in_valid        (in_valid),
      .in_byte         (in_byte)
   );

   wsd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .in_byte       (in_byte),
      .frame_limit   (frame_limit_ff),
      .expect_masked (expect_masked_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   wsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_word (res),
      .room_free (room_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // result word onto the ports
   assign rsp_is_header        = rsp_word.is_header;
   assign rsp_data_byte        = rsp_word.data_byte;
   assign rsp_fin              = rsp_word.fin;
   assign rsp_rsv_bits         = rsp_word.rsv_bits;
   assign rsp_opcode           = rsp_word.opcode;
   assign rsp_masked           = rsp_word.masked;
   assign rsp_payload_length   = rsp_word.payload_length;
   assign rsp_last             = rsp_word.last;
   assign rsp_length_violation = rsp_word.length_violation;
   assign rsp_oversize         = rsp_word.oversize;
   assign rsp_mask_mismatch    = rsp_word.mask_mismatch;

endmodule
